>>> hdl/pllcr_pkg.sv
`default_nettype none
package pllcr_pkg;

   // Reference clock in hertz
   localparam int unsigned REF_FREQ_HZ = 12000000;
   localparam int REF_W = $clog2(REF_FREQ_HZ + 1);

   localparam int FB_W = 12;
   localparam int REFDIV_W = 6;
   localparam int PD_W = 3;
   localparam int PDP_W = 2 * PD_W;
   localparam int DEN_W = REFDIV_W + PDP_W;
   localparam int NUM_W = REF_W + FB_W;
   localparam int CNT_W = $clog2(NUM_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register offsets
   localparam logic [11:0] OFF_CS = 12'h000;
   localparam logic [11:0] OFF_PWR = 12'h004;
   localparam logic [11:0] OFF_FBDIV = 12'h008;
   localparam logic [11:0] OFF_PRIM = 12'h00C;

   // Register select codes
   localparam logic [2:0] SEL_CS = 3'd0;
   localparam logic [2:0] SEL_PWR = 3'd1;
   localparam logic [2:0] SEL_FBDIV = 3'd2;
   localparam logic [2:0] SEL_PRIM = 3'd3;
   localparam logic [2:0] SEL_NONE = 3'd4;

   // Atomic alias codes
   localparam logic [1:0] AOP_PLAIN = 2'd0;
   localparam logic [1:0] AOP_XOR = 2'd1;
   localparam logic [1:0] AOP_SET = 2'd2;
   localparam logic [1:0] AOP_CLR = 2'd3;

   localparam logic [8:0] CS_WMASK = 9'h13F;
   localparam logic [5:0] PWR_WMASK = 6'h2D;
   localparam logic [11:0] FBDIV_WMASK = 12'hFFF;
   localparam logic [18:0] PRIM_WMASK = 19'h77000;

   localparam logic [8:0] CS_RESET = 9'h001;
   localparam logic [5:0] PWR_RESET = 6'h2D;
   localparam logic [11:0] FBDIV_RESET = 12'h000;
   localparam logic [18:0] PRIM_RESET = 19'h77000;

   typedef struct packed {
      logic        req_type;
      logic [13:0] bus_address;
      logic [31:0] write_data;
   } pllcr_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] out_freq_hz;
   } pllcr_rsp_type;

   typedef struct packed {
      logic        is_write;
      logic [2:0]  sel;
      logic [1:0]  aop;
      logic [31:0] data;
   } pllcr_cmd_type;

   typedef struct packed {
      logic busy;
      logic rsp_load;
   } pllcr_back_status_type;

endpackage
`default_nettype wire

>>> hdl/pllcr_front.sv
`default_nettype none
module pllcr_front (
   input  wire                      req_push,
   input  pllcr_pkg::pllcr_req_type req_data,
   input  wire                      q_full,
   output logic                     req_full,
   output logic                     q_push,
   output pllcr_pkg::pllcr_cmd_type q_cmd
);
   import pllcr_pkg::*;

   logic [11:0] offset;

   assign offset = req_data.bus_address[11:0];
   assign req_full = q_full;
   assign q_push = req_push && !q_full;

   // Decode the offset; the alias bits matter only to writes
   always_comb begin
      q_cmd.is_write = req_data.req_type;
      q_cmd.aop = req_data.bus_address[13:12];
      q_cmd.data = req_data.write_data;
      case (offset)
         OFF_CS: q_cmd.sel = SEL_CS;
         OFF_PWR: q_cmd.sel = SEL_PWR;
         OFF_FBDIV: q_cmd.sel = SEL_FBDIV;
         OFF_PRIM: q_cmd.sel = SEL_PRIM;
         default: q_cmd.sel = SEL_NONE;
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/pllcr_cmd_queue.sv
`default_nettype none
module pllcr_cmd_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  pllcr_pkg::pllcr_cmd_type push_cmd,
   input  wire                      pop,
   output logic                     full,
   output logic                     empty,
   output pllcr_pkg::pllcr_cmd_type head
);
   import pllcr_pkg::*;

   pllcr_cmd_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> hdl/pllcr_back.sv
`default_nettype none
module pllcr_back (
   input  wire                              clock,
   input  wire                              reset,
   input  pllcr_pkg::pllcr_cmd_type         cmd,
   input  wire                              cmd_empty,
   output logic                             cmd_pop,
   input  wire  [31:0]                      fallback_freq,
   input  wire                              rsp_pop,
   output logic                             rsp_empty,
   output pllcr_pkg::pllcr_rsp_type         rsp_data,
   output pllcr_pkg::pllcr_back_status_type status
);
   import pllcr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL = 3'd1;
   localparam logic [2:0] S_DEN = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [8:0] cs_ff, cs_in;
   logic [5:0] pwr_ff, pwr_in;
   logic [11:0] fb_ff, fb_in;
   logic [18:0] prim_ff, prim_in;
   logic [31:0] rd_ff, rd_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [PDP_W-1:0] pdp_ff, pdp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   pllcr_rsp_type rsp_ff, rsp_in;

   logic [31:0] old_val, new_val;
   logic locked;
   logic [REFDIV_W-1:0] refdiv_eff;
   logic [PD_W-1:0] pd1, pd2;
   logic [DEN_W:0] trial;
   logic ge;
   logic [63:0] quot_ext;
   logic [31:0] freq_sat;
   logic slot_free;

   function automatic logic [31:0] apply_aop(input logic [31:0] old,
                                             input logic [31:0] val,
                                             input logic [1:0] aop);
      logic [31:0] res;
      case (aop)
         AOP_XOR: res = old ^ val;
         AOP_SET: res = old | val;
         AOP_CLR: res = old & ~val;
         default: res = val;
      endcase
      return res;
   endfunction

   assign locked = (pwr_ff[0] == 1'b0) && (pwr_ff[5] == 1'b0);
   assign refdiv_eff = (cs_ff[5:0] == '0) ? REFDIV_W'(1) : cs_ff[5:0];
   assign pd1 = prim_ff[18:16];
   assign pd2 = prim_ff[14:12];
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign ge = (trial >= {1'b0, den_ff});
   assign quot_ext = 64'(num_ff);
   assign freq_sat = (|quot_ext[63:32]) ? 32'hFFFF_FFFF : quot_ext[31:0];
   assign slot_free = !rsp_valid_ff || rsp_pop;

   assign cmd_pop = (state_ff == S_IDLE) && !cmd_empty;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign status.busy = (state_ff != S_IDLE);
   assign status.rsp_load = (state_ff == S_DONE) && slot_free;

   // Register file: old value for the selected register, alias applied
   always_comb begin
      case (cmd.sel)
         SEL_CS: old_val = 32'(cs_ff);
         SEL_PWR: old_val = 32'(pwr_ff);
         SEL_FBDIV: old_val = 32'(fb_ff);
         SEL_PRIM: old_val = 32'(prim_ff);
         default: old_val = '0;
      endcase
      new_val = apply_aop(old_val, cmd.data, cmd.aop);
   end

   always_comb begin
      state_in = state_ff;
      cs_in = cs_ff;
      pwr_in = pwr_ff;
      fb_in = fb_ff;
      prim_in = prim_ff;
      rd_in = rd_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      pdp_in = pdp_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               rd_in = '0;
               if (cmd.is_write) begin
                  case (cmd.sel)
                     SEL_CS: cs_in = new_val[8:0] & CS_WMASK;
                     SEL_PWR: pwr_in = new_val[5:0] & PWR_WMASK;
                     SEL_FBDIV: fb_in = new_val[11:0] & FBDIV_WMASK;
                     SEL_PRIM: prim_in = new_val[18:0] & PRIM_WMASK;
                     default: ;
                  endcase
               end else begin
                  case (cmd.sel)
                     SEL_CS: rd_in = {locked, 22'd0, cs_ff & CS_WMASK};
                     default: rd_in = old_val;
                  endcase
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            rem_in = '0;
            cnt_in = CNT_W'(NUM_W - 1);
            if (!locked || pwr_ff[3]) begin
               num_in = '0;
               state_in = S_DONE;
            end else if (cs_ff[8]) begin
               num_in = NUM_W'(REF_FREQ_HZ);
               den_in = DEN_W'(refdiv_eff);
               state_in = S_DIV;
            end else if (fb_ff == '0 || pd1 == '0 || pd2 == '0) begin
               num_in = NUM_W'(fallback_freq);
               state_in = S_DONE;
            end else begin
               num_in = NUM_W'(REF_FREQ_HZ) * NUM_W'(fb_ff);
               pdp_in = PDP_W'(pd1) * PDP_W'(pd2);
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            den_in = DEN_W'(refdiv_eff) * DEN_W'(pdp_ff);
            state_in = S_DIV;
         end
         S_DIV: begin
            // One restoring step per cycle, quotient shifts into num
            rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.read_data = rd_ff;
               rsp_in.out_freq_hz = freq_sat;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cs_ff <= CS_RESET;
         pwr_ff <= PWR_RESET;
         fb_ff <= FBDIV_RESET;
         prim_ff <= PRIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cs_ff <= cs_in;
         pwr_ff <= pwr_in;
         fb_ff <= fb_in;
         prim_ff <= prim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      pdp_ff <= pdp_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

>>> hdl/pll_control_registers_unit.sv
// PLL control register unit.
// Requests arrive on a queue-style port: a request (read or write, 14-bit
// bus address, 32-bit write data) is taken at a clock edge where req_push is
// high and req_full is low. Each request gives exactly one response, in
// order: rsp_empty low means the oldest response is on rsp_data, and it is
// taken at an edge where rsp_pop is high. The response carries the read data
// (zero for writes and unknown offsets) and the PLL output frequency after
// the access.
// The fallback frequency register is written over the csr_ port, which is
// always ready; write it only while no request is in flight.
// A request steps through the idle, multiply, denominator, divide and done
// states; bypass skips the denominator state, and a zero or fallback result
// goes from multiply to done. A 36-step restoring divider, one quotient bit
// per cycle, does the divide. One request is worked at a time.
// A two-entry request queue sits ahead of the register/divider engine, so
// two further requests are taken while one is being worked on.
// A stalled receiver holds the response; the engine then finishes its next
// request and waits, and the queue fills and raises req_full.
// Synchronous reset empties the queue and the response slot and restores the
// defaults: refdiv one, all power-down bits set, post dividers seven, fallback zero.
`default_nettype none
module pll_control_registers_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_push,
   output logic                     req_full,
   input  pllcr_pkg::pllcr_req_type req_data,
   output logic                     rsp_empty,
   input  wire                      rsp_pop,
   output pllcr_pkg::pllcr_rsp_type rsp_data,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [31:0]              csr_data
);
   import pllcr_pkg::*;

   logic q_push;
   logic q_full;
   logic q_empty;
   logic cmd_pop;
   pllcr_cmd_type q_cmd;
   pllcr_cmd_type head_cmd;
   pllcr_back_status_type back_status;
   logic [31:0] fallback_ff;

   // Fallback frequency register: take every write, no wait states
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         fallback_ff <= csr_data;
      end
   end

   // Front: decode offset and alias into a command
   pllcr_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .req_full (req_full),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   // Decouple the decoder from the engine
   pllcr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (cmd_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head_cmd)
   );

   // Back: update registers, then work out the output frequency
   pllcr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd           (head_cmd),
      .cmd_empty     (q_empty),
      .cmd_pop       (cmd_pop),
      .fallback_freq (fallback_ff),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_data      (rsp_data),
      .status        (back_status)
   );

   // Never start a command from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !q_empty)
      else $error("command taken from empty queue");

   // Never overwrite a response that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      back_status.rsp_load |-> (rsp_empty || rsp_pop))
      else $error("pending response overwritten");

   // An accepted request leaves the queue non-empty or the engine busy
   assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> (!q_empty || back_status.busy))
      else $error("accepted request lost");

   // The engine starts only from idle
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !back_status.busy)
      else $error("command started while busy");

endmodule
`default_nettype wire
